@@ hdl/xcflr_pkg.sv @@
package xcflr_pkg;

    localparam int FRAME_BYTES_DEF = 5;
    localparam int OUT_DATA_W      = 40;
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int RETRY_W         = 4;

    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_RETRY_LIMIT = 2'd0;

    // action codes of an input transfer
    localparam logic [1:0] ACT_RX_BYTE = 2'd0;
    localparam logic [1:0] ACT_HS_SENT = 2'd1;
    localparam logic [1:0] ACT_CMD     = 2'd2;

    // link bytes
    localparam logic [7:0] TX_HANDSHAKE = 8'hAA;
    localparam logic [7:0] TX_ACK       = 8'hD0;
    localparam logic [7:0] TX_REJECT    = 8'hDF;
    localparam logic [7:0] HS_FILL      = 8'hBB;
    localparam logic [7:0] ERR_MARK     = 8'hFF;

    // event codes
    localparam logic [2:0] EV_HS_SENT    = 3'd0;
    localparam logic [2:0] EV_CHK_REJECT = 3'd1;
    localparam logic [2:0] EV_RESEND     = 3'd2;
    localparam logic [2:0] EV_LINK_OK    = 3'd3;
    localparam logic [2:0] EV_RETRY      = 3'd4;
    localparam logic [2:0] EV_FAILED     = 3'd5;
    localparam logic [2:0] EV_DELIVER    = 3'd6;

    typedef struct packed {
        logic done;
        logic sum_ok;
    } t_frame_stat;

    typedef struct packed {
        logic                  valid;
        logic [7:0]            tx_byte;
        logic [2:0]            event_res;
        logic [OUT_DATA_W-1:0] frame_data;
        logic                  link_ok;
    } t_result;

endpackage

@@ hdl/xcflr_in_if.sv @@
interface xcflr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

@@ hdl/xcflr_out_if.sv @@
interface xcflr_out_if;
    logic                              valid;
    logic                              ready;
    logic [7:0]                        tx_byte;
    logic [2:0]                        event_res;
    logic [xcflr_pkg::OUT_DATA_W-1:0]  frame_data;
    logic                              link_ok;

    modport source (output valid, output tx_byte, output event_res, output frame_data,
                    output link_ok, input ready);
    modport sink   (input valid, input tx_byte, input event_res, input frame_data,
                    input link_ok, output ready);
endinterface

@@ hdl/xcflr_assembler.sv @@
module xcflr_assembler #(
    parameter int FRAME_BYTES = xcflr_pkg::FRAME_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [7:0]                    i_rx_byte,
    output xcflr_pkg::t_frame_stat        o_stat,
    output logic [8*FRAME_BYTES-1:0]      o_frame
);
    localparam int FW = 8 * FRAME_BYTES;
    localparam int CW = $clog2(FRAME_BYTES);

    logic [FW-1:0] r_frame, n_frame;
    logic [7:0]    r_xor,   n_xor;
    logic [CW-1:0] r_count;
    logic          last;

    assign n_frame = {r_frame[FW-9:0], i_rx_byte};
    assign n_xor   = r_xor ^ i_rx_byte;
    assign last    = (r_count == CW'(FRAME_BYTES - 1));

    assign o_frame       = n_frame;
    assign o_stat.done   = last;
    assign o_stat.sum_ok = (n_xor == 8'h00);

    // shift in, clear once the frame is complete
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_xor   <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            if (last) begin
                r_frame <= '0;
                r_xor   <= '0;
                r_count <= '0;
            end else begin
                r_frame <= n_frame;
                r_xor   <= n_xor;
                r_count <= r_count + 1'b1;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FRAME_BYTES - 1))
        else $error("byte count past frame length");

    a_clear_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && last) |=> (r_count == '0 && r_xor == 8'h00))
        else $error("frame state not cleared after last byte");

endmodule

@@ hdl/xcflr_link_ctrl.sv @@
module xcflr_link_ctrl #(
    parameter int FRAME_BYTES = xcflr_pkg::FRAME_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_fire,
    input  logic [1:0]                        i_action,
    input  xcflr_pkg::t_frame_stat            i_stat,
    input  logic [8*FRAME_BYTES-1:0]          i_frame,
    input  logic [xcflr_pkg::RETRY_W-1:0]     i_retry_limit,
    output xcflr_pkg::t_result                o_res
);
    localparam int FW = 8 * FRAME_BYTES;
    localparam int OW = xcflr_pkg::OUT_DATA_W;

    logic                           r_pending, n_pending;
    logic                           r_link_up, n_link_up;
    logic [xcflr_pkg::RETRY_W-1:0]  r_retry,   n_retry;
    logic [xcflr_pkg::RETRY_W-1:0]  limit;
    logic [OW-1:0]                  frame_out;
    logic [FRAME_BYTES-2:0]         fill_ok;
    logic                           is_reply;
    logic                           err_mark;

    generate
        if (FW >= OW) begin : g_trunc
            assign frame_out = i_frame[OW-1:0];
        end else begin : g_ext
            assign frame_out = {{(OW-FW){1'b0}}, i_frame};
        end
    endgenerate

    // all bytes but the last must be the fill byte
    always_comb begin
        for (int b = 0; b < FRAME_BYTES - 1; b++) begin
            fill_ok[b] = (i_frame[FW-1-8*b -: 8] == xcflr_pkg::HS_FILL);
        end
    end

    assign is_reply = (&fill_ok) && (i_frame[7:0] == 8'h00);
    assign err_mark = (i_frame[FW-1 -: 8] == xcflr_pkg::ERR_MARK) ||
                      (i_frame[FW-17 -: 8] == xcflr_pkg::ERR_MARK);
    assign limit    = (i_retry_limit == '0) ? xcflr_pkg::RETRY_W'(1) : i_retry_limit;

    always_comb begin
        n_pending        = r_pending;
        n_link_up        = r_link_up;
        n_retry          = r_retry;
        o_res.valid      = 1'b0;
        o_res.tx_byte    = xcflr_pkg::TX_ACK;
        o_res.event_res  = xcflr_pkg::EV_DELIVER;
        o_res.frame_data = frame_out;
        if (i_valid) begin
            case (i_action)
                xcflr_pkg::ACT_HS_SENT: begin
                    n_pending        = 1'b1;
                    o_res.valid      = 1'b1;
                    o_res.tx_byte    = xcflr_pkg::TX_HANDSHAKE;
                    o_res.event_res  = xcflr_pkg::EV_HS_SENT;
                    o_res.frame_data = '0;
                end
                xcflr_pkg::ACT_CMD: begin
                    n_pending = 1'b0;
                end
                xcflr_pkg::ACT_RX_BYTE: begin
                    if (i_stat.done) begin
                        o_res.valid = 1'b1;
                        if (!i_stat.sum_ok) begin
                            o_res.tx_byte   = xcflr_pkg::TX_REJECT;
                            o_res.event_res = xcflr_pkg::EV_CHK_REJECT;
                        end else if (err_mark) begin
                            o_res.event_res = xcflr_pkg::EV_RESEND;
                        end else if (!r_pending) begin
                            o_res.event_res = xcflr_pkg::EV_DELIVER;
                        end else if (r_retry >= limit) begin
                            o_res.event_res = xcflr_pkg::EV_FAILED;
                        end else if (is_reply) begin
                            n_link_up       = 1'b1;
                            o_res.event_res = xcflr_pkg::EV_LINK_OK;
                        end else begin
                            n_retry         = r_retry + 1'b1;
                            o_res.event_res = (n_retry >= limit) ? xcflr_pkg::EV_FAILED
                                                                 : xcflr_pkg::EV_RETRY;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        o_res.link_ok = n_link_up;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_link_up <= 1'b0;
            r_retry   <= '0;
        end else if (i_fire) begin
            r_pending <= n_pending;
            r_link_up <= n_link_up;
            r_retry   <= n_retry;
        end
    end

    a_link_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link_up |=> r_link_up)
        else $error("link_up dropped without reset");

    a_retry_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_retry != '0 |=> r_retry >= $past(r_retry))
        else $error("retry count went backwards");

endmodule

@@ hdl/xor_checked_frame_link_receiver_unit.sv @@
// Receiver for a small byte-serial link with XOR-checked frames.
//
// Input channel i_rx: one transfer per event. action selects a received byte
// (rx_byte valid), a handshake request just sent, or an ordinary command sent.
// Received bytes are gathered into FRAME_BYTES-byte frames; a completed frame,
// and every handshake request, yields one transfer on o_tx carrying the byte
// to send back, an event code, the frame (last five bytes, first byte most
// significant) and the link status. Other transfers yield no output.
//
// A result passes the input register, then the result register, before it
// appears on o_tx. Throughput: one input transfer per cycle while o_tx does not
// stall, set by the single pass through the frame and link logic.
//
// Reset (synchronous, active low) clears the frame, XOR, count, handshake and
// retry state, empties both registers and loads retry_limit with 3.
// When o_tx stalls, the result register holds and the input register keeps
// the next item; i_rx.ready drops only once both are occupied.
// APB register 0 (byte address 0): retry_limit, bits 3:0. Write only while idle.
module xor_checked_frame_link_receiver_unit #(
    parameter int FRAME_BYTES = xcflr_pkg::FRAME_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    xcflr_in_if.sink                            i_rx,
    xcflr_out_if.source                         o_tx,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [xcflr_pkg::CFG_ADDR_W-1:0]    i_paddr,
    input  logic [xcflr_pkg::CFG_DATA_W-1:0]    i_pwdata,
    output logic [xcflr_pkg::CFG_DATA_W-1:0]    o_prdata,
    output logic                                o_pready
);
    localparam int FW = 8 * FRAME_BYTES;

    // configuration register
    logic [xcflr_pkg::RETRY_W-1:0] r_retry_limit;
    logic                          cfg_wr;

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_action;
    logic [7:0] r_in_byte;

    // result register
    logic               r_out_valid;
    xcflr_pkg::t_result r_out;

    xcflr_pkg::t_frame_stat frame_stat;
    xcflr_pkg::t_result     res;
    logic [FW-1:0]          frame;
    logic                   out_free;
    logic                   advance;
    logic                   asm_fire;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite &&
                      (i_paddr == xcflr_pkg::ADDR_RETRY_LIMIT);
    assign o_prdata = (i_paddr == xcflr_pkg::ADDR_RETRY_LIMIT)
                    ? {{(xcflr_pkg::CFG_DATA_W - xcflr_pkg::RETRY_W){1'b0}}, r_retry_limit}
                    : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= xcflr_pkg::RETRY_LIMIT_RST;
        end else if (cfg_wr) begin
            r_retry_limit <= i_pwdata[xcflr_pkg::RETRY_W-1:0];
        end
    end

    // the result slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || o_tx.ready;
    // advance the held item unless its result has nowhere to go
    assign advance  = r_in_valid && (!res.valid || out_free);
    assign asm_fire = advance && (r_in_action == xcflr_pkg::ACT_RX_BYTE);
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_action <= i_rx.action;
            r_in_byte   <= i_rx.rx_byte;
        end
    end

    xcflr_assembler #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_asm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (asm_fire),
        .i_rx_byte (r_in_byte),
        .o_stat    (frame_stat),
        .o_frame   (frame)
    );

    xcflr_link_ctrl #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_fire        (advance),
        .i_action      (r_in_action),
        .i_stat        (frame_stat),
        .i_frame       (frame),
        .i_retry_limit (r_retry_limit),
        .o_res         (res)
    );

    // load a new result, or drop the taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_out <= res;
        end
    end

    assign o_tx.valid      = r_out_valid;
    assign o_tx.tx_byte    = r_out.tx_byte;
    assign o_tx.event_res  = r_out.event_res;
    assign o_tx.frame_data = r_out.frame_data;
    assign o_tx.link_ok    = r_out.link_ok;

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && res.valid) |=> r_out_valid)
        else $error("result of an advanced item was lost");

    a_ready_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> (r_in_valid && r_out_valid && !o_tx.ready))
        else $error("input stalled while the pipeline could move");

endmodule
